@@ rtl/deet_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deet_pkg
// Shared codes and widths of the device event edge tracer.
// ----------------------------------------------------------------------------
package deet_pkg;

    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned IRQ_N     = 6;
    localparam int unsigned SLOT_N    = 10;
    localparam int unsigned SLOT_W    = 4;
    localparam int unsigned LINE_W    = 10;

    // event slot order within one poll
    localparam logic [SLOT_W-1:0] SLOT_PI   = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_SI   = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_AI   = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_IRQ0 = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_VI   = 4'd9;

    localparam logic [2:0] KIND_DMA_START = 3'd0;
    localparam logic [2:0] KIND_DMA_DONE  = 3'd1;
    localparam logic [2:0] KIND_IRQ_RAISE = 3'd2;
    localparam logic [2:0] KIND_IRQ_ACK   = 3'd3;
    localparam logic [2:0] KIND_RETRACE   = 3'd4;
    localparam logic [2:0] KIND_PI_DONE   = 3'd5;

    localparam logic [2:0] DEV_PI = 3'd0;
    localparam logic [2:0] DEV_SI = 3'd1;
    localparam logic [2:0] DEV_AI = 3'd2;
    localparam logic [2:0] DEV_MI = 3'd3;
    localparam logic [2:0] DEV_VI = 3'd4;

    localparam logic [0:0] REG_OUTPUT_MODE = 1'b0;

    localparam logic [31:0] LEN_IDLE = 32'h0000_007F;

    typedef logic [SLOT_N-1:0] t_slot_mask;

endpackage

@@ rtl/device_event_edge_tracer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// device_event_edge_tracer
// Compares each polled device snapshot with the previous one and emits
// cycle-stamped, sequence-numbered DMA, interrupt and retrace events.
// ----------------------------------------------------------------------------
// A poll is accepted on its valid/ready handshake; its edges are detected at
// acceptance and held as a mask of pending events, which drains through the
// output register at one event per cycle while i_ready does not stall it.
// The next poll is taken in the cycle the last of its events is loaded, or
// whenever no events are pending. The baseline poll after reset causes no
// events. output_mode is sampled at the edge of each poll.
module device_event_edge_tracer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // poll words
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [31:0]                   i_cycle_stamp,
    input  logic [2:0]                    i_busy_flags,
    input  logic [31:0]                   i_pi_read_length,
    input  logic [31:0]                   i_pi_write_length,
    input  logic [31:0]                   i_pi_cart_address,
    input  logic [31:0]                   i_pi_dram_address,
    input  logic [31:0]                   i_si_dram_address,
    input  logic [31:0]                   i_ai_dram_address,
    input  logic [31:0]                   i_ai_length,
    input  logic [5:0]                    i_interrupt_bits,
    input  logic [9:0]                    i_video_line,
    // event words
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [63:0]                   o_sequence_number,
    output logic [2:0]                    o_event_type,
    output logic [2:0]                    o_device_id,
    output logic [31:0]                   o_event_cycle,
    output logic [31:0]                   o_address_or_source,
    output logic [31:0]                   o_value_or_length,
    output logic [31:0]                   o_dram_address_out,
    output logic                          o_last_event,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [deet_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import deet_pkg::*;

    logic                r_mode;
    logic                r_primed;
    logic [63:0]         r_seq;
    logic                r_pi_prev, r_si_prev, r_ai_prev;
    logic [31:0]         r_pi_cart_sv, r_pi_dram_sv, r_pi_len_sv;
    logic [31:0]         r_si_dram_sv, r_ai_dram_sv, r_ai_len_sv;
    logic [IRQ_N-1:0]    r_irq_prev;
    logic [LINE_W-1:0]   r_line_prev;

    // pending events of the current poll
    t_slot_mask          r_mask;
    t_slot_mask          n_mask;
    logic [31:0]         r_cyc;
    logic [2:0]          r_pi_kind;
    logic [31:0]         r_pi_addr, r_pi_val, r_pi_dram;
    logic [2:0]          r_si_kind;
    logic [31:0]         r_si_addr;
    logic [2:0]          r_ai_kind;
    logic [31:0]         r_ai_addr, r_ai_val;
    logic [IRQ_N-1:0]    r_irq_raise;

    logic                w_accept, w_drain, w_cfg_wr;
    logic                w_pi_b, w_si_b, w_ai_b, w_pi_rise, w_pi_fall;
    logic                w_si_rise, w_si_fall, w_ai_rise, w_ai_fall;
    logic [31:0]         w_pi_len;
    logic [IRQ_N-1:0]    w_raised, w_acked;
    logic                w_retrace;
    t_slot_mask          w_pick, w_rest;
    logic [SLOT_W-1:0]   w_idx;
    logic [SLOT_W-1:0]   w_irq_k;

    logic                n_pi_ev;
    logic [2:0]          n_pi_kind;
    logic [31:0]         n_pi_addr, n_pi_val, n_pi_dram;

    logic [2:0]          n_kind, n_dev;
    logic [31:0]         n_addr, n_val, n_dram;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_OUTPUT_MODE) ? {31'd0, r_mode} : 32'd0;

    assign w_pick  = r_mask & (~r_mask + t_slot_mask'(1));
    assign w_rest  = r_mask & ~w_pick;
    assign w_drain = (|r_mask) && (!o_valid || i_ready);
    assign o_ready = (w_drain ? w_rest : r_mask) == '0;
    assign w_accept = i_valid && o_ready;

    assign w_pi_b    = i_busy_flags[0];
    assign w_si_b    = i_busy_flags[1];
    assign w_ai_b    = i_busy_flags[2];
    assign w_pi_rise = w_pi_b && !r_pi_prev;
    assign w_pi_fall = !w_pi_b && r_pi_prev;
    assign w_si_rise = w_si_b && !r_si_prev;
    assign w_si_fall = !w_si_b && r_si_prev;
    assign w_ai_rise = w_ai_b && !r_ai_prev;
    assign w_ai_fall = !w_ai_b && r_ai_prev;
    assign w_raised  = i_interrupt_bits & ~r_irq_prev;
    assign w_acked   = r_irq_prev & ~i_interrupt_bits;
    assign w_retrace = i_video_line < r_line_prev;

    always_comb begin
        priority if (i_pi_read_length != LEN_IDLE) begin
            w_pi_len = i_pi_read_length + 32'd1;
        end else if (i_pi_write_length != LEN_IDLE) begin
            w_pi_len = i_pi_write_length + 32'd1;
        end else begin
            w_pi_len = 32'd0;
        end
    end

    always_comb begin
        n_pi_ev   = 1'b0;
        n_pi_kind = KIND_DMA_START;
        n_pi_addr = i_pi_cart_address;
        n_pi_val  = w_pi_len;
        n_pi_dram = 32'd0;
        priority if (w_pi_rise) begin
            n_pi_ev = !r_mode;
        end else if (w_pi_fall) begin
            n_pi_addr = r_pi_cart_sv;
            n_pi_val  = r_pi_len_sv;
            if (r_mode) begin
                n_pi_ev   = r_pi_len_sv != 32'd0;
                n_pi_kind = KIND_PI_DONE;
                n_pi_dram = r_pi_dram_sv;
            end else begin
                n_pi_ev   = 1'b1;
                n_pi_kind = KIND_DMA_DONE;
            end
        end else begin
            n_pi_ev = 1'b0;
        end
    end

    // an accepted poll replaces the mask, its last event drains in the same cycle
    always_comb begin
        priority if (w_accept && r_primed) begin
            n_mask = {w_retrace, w_raised | w_acked,
                      w_ai_rise || w_ai_fall, w_si_rise || w_si_fall, n_pi_ev};
        end else if (w_accept) begin
            n_mask = '0;
        end else if (w_drain) begin
            n_mask = w_rest;
        end else begin
            n_mask = r_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_primed     <= 1'b0;
            r_pi_prev    <= 1'b0;
            r_si_prev    <= 1'b0;
            r_ai_prev    <= 1'b0;
            r_pi_cart_sv <= 32'd0;
            r_pi_dram_sv <= 32'd0;
            r_pi_len_sv  <= 32'd0;
            r_si_dram_sv <= 32'd0;
            r_ai_dram_sv <= 32'd0;
            r_ai_len_sv  <= 32'd0;
            r_irq_prev   <= '0;
            r_line_prev  <= '0;
            r_mask       <= '0;
        end else begin
            if (w_cfg_wr && paddr[2] == REG_OUTPUT_MODE) begin
                r_mode <= pwdata[0];
            end
            r_mask <= n_mask;
            if (w_accept) begin
                r_primed    <= 1'b1;
                r_pi_prev   <= w_pi_b;
                r_si_prev   <= w_si_b;
                r_ai_prev   <= w_ai_b;
                r_irq_prev  <= i_interrupt_bits;
                r_line_prev <= i_video_line;
                if (!r_primed) begin
                    r_pi_cart_sv <= i_pi_cart_address;
                    r_pi_dram_sv <= i_pi_dram_address;
                    r_pi_len_sv  <= 32'd0;
                    r_si_dram_sv <= i_si_dram_address;
                    r_ai_dram_sv <= i_ai_dram_address;
                    r_ai_len_sv  <= i_ai_length;
                end else begin
                    if (w_pi_rise) begin
                        r_pi_cart_sv <= i_pi_cart_address;
                        r_pi_dram_sv <= i_pi_dram_address;
                        r_pi_len_sv  <= w_pi_len;
                    end
                    if (w_si_rise) begin
                        r_si_dram_sv <= i_si_dram_address;
                    end
                    if (w_ai_rise) begin
                        r_ai_dram_sv <= i_ai_dram_address;
                        r_ai_len_sv  <= i_ai_length;
                    end
                end
            end
        end
    end

    // payload of the pending poll
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cyc       <= i_cycle_stamp;
            r_pi_kind   <= n_pi_kind;
            r_pi_addr   <= n_pi_addr;
            r_pi_val    <= n_pi_val;
            r_pi_dram   <= n_pi_dram;
            r_si_kind   <= w_si_rise ? KIND_DMA_START : KIND_DMA_DONE;
            r_si_addr   <= w_si_rise ? i_si_dram_address : r_si_dram_sv;
            r_ai_kind   <= w_ai_rise ? KIND_DMA_START : KIND_DMA_DONE;
            r_ai_addr   <= w_ai_rise ? i_ai_dram_address : r_ai_dram_sv;
            r_ai_val    <= w_ai_rise ? i_ai_length : r_ai_len_sv;
            r_irq_raise <= w_raised;
        end
    end

    // lowest pending slot
    always_comb begin
        w_idx = SLOT_PI;
        for (int i = SLOT_N - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_idx = SLOT_W'(i);
            end
        end
    end

    assign w_irq_k = w_idx - SLOT_IRQ0;

    always_comb begin
        n_kind = KIND_RETRACE;
        n_dev  = DEV_VI;
        n_addr = 32'd0;
        n_val  = 32'd0;
        n_dram = 32'd0;
        priority if (w_idx == SLOT_PI) begin
            n_kind = r_pi_kind;
            n_dev  = DEV_PI;
            n_addr = r_pi_addr;
            n_val  = r_pi_val;
            n_dram = r_pi_dram;
        end else if (w_idx == SLOT_SI) begin
            n_kind = r_si_kind;
            n_dev  = DEV_SI;
            n_addr = r_si_addr;
        end else if (w_idx == SLOT_AI) begin
            n_kind = r_ai_kind;
            n_dev  = DEV_AI;
            n_addr = r_ai_addr;
            n_val  = r_ai_val;
        end else if (w_idx < SLOT_VI) begin
            n_kind = r_irq_raise[w_irq_k[2:0]] ? KIND_IRQ_RAISE : KIND_IRQ_ACK;
            n_dev  = DEV_MI;
            n_addr = 32'd1 << w_irq_k[2:0];
        end else begin
            n_kind = KIND_RETRACE;
            n_dev  = DEV_VI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_seq   <= 64'd1;
        end else begin
            if (w_drain) begin
                o_valid <= 1'b1;
                r_seq   <= r_seq + 64'd1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_drain) begin
            o_sequence_number   <= r_seq;
            o_event_type        <= n_kind;
            o_device_id         <= n_dev;
            o_event_cycle       <= r_cyc;
            o_address_or_source <= n_addr;
            o_value_or_length   <= n_val;
            o_dram_address_out  <= n_dram;
            o_last_event        <= w_rest == '0;
        end
    end

endmodule

@@ rtl/deet_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deet_checker
// Port-level checks of the device event edge tracer, bound to the top level.
// ----------------------------------------------------------------------------
module deet_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_ready,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [63:0] o_sequence_number,
    input  logic [2:0]  o_event_type,
    input  logic [2:0]  o_device_id,
    input  logic [31:0] o_address_or_source,
    input  logic        o_last_event
);
    import deet_pkg::*;

    logic        r_seen;
    logic [63:0] r_last_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (o_valid && i_ready) begin
            r_seen     <= 1'b1;
            r_last_seq <= o_sequence_number;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sequence_number))
        else $error("stalled event word changed");

    a_seq_dense: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && r_seen |-> o_sequence_number == r_last_seq + 64'd1)
        else $error("sequence number not dense");

    a_poll_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_event && !i_ready |-> !o_ready)
        else $error("poll taken while events of the previous poll remain");

    a_irq_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_type == KIND_IRQ_RAISE || o_event_type == KIND_IRQ_ACK)
        |-> $onehot(o_address_or_source[5:0]) && o_address_or_source[31:6] == 26'd0
            && o_device_id == DEV_MI)
        else $error("interrupt event source not one-hot");

endmodule

bind device_event_edge_tracer deet_checker u_deet_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the device event edge tracer. Poll words go in on a
// valid/ready channel and event words are checked one by one against a
// scoreboard that tracks busy, interrupt and line-counter edges on its own.
// A directed part covers the full ten-event polls, the PI length rules and the
// headless output mode. Random phases then switch the mode over APB and vary
// the gaps on the poll side and the stalls on the event side.
// ----------------------------------------------------------------------------
module tb_top;
    import deet_pkg::*;

    localparam bit          MODE_TIMING   = 1'b0;
    localparam bit          MODE_HEADLESS = 1'b1;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam logic [PADDR_W-1:0] MODE_ADDR = PADDR_W'(REG_OUTPUT_MODE) << 2;

    typedef struct {
        logic [31:0] cycle_stamp;
        logic [2:0]  busy_flags;
        logic [31:0] pi_read_length;
        logic [31:0] pi_write_length;
        logic [31:0] pi_cart_address;
        logic [31:0] pi_dram_address;
        logic [31:0] si_dram_address;
        logic [31:0] ai_dram_address;
        logic [31:0] ai_length;
        logic [5:0]  interrupt_bits;
        logic [9:0]  video_line;
    } t_poll;

    typedef struct {
        logic [63:0] seq;
        logic [2:0]  kind;
        logic [2:0]  dev;
        logic [31:0] cyc;
        logic [31:0] addr;
        logic [31:0] val;
        logic [31:0] dram;
        logic        last;
    } t_event;

    class t_edge_board;
        t_event      events_due[$];
        t_event      poll_events[$];
        int unsigned mismatches;
        int unsigned events_seen;
        bit          headless;
        bit          primed;
        bit          pi_busy_q;
        bit          si_busy_q;
        bit          ai_busy_q;
        logic [63:0] next_seq;
        logic [31:0] pi_cart_q;
        logic [31:0] pi_dram_q;
        logic [31:0] pi_len_q;
        logic [31:0] si_dram_q;
        logic [31:0] ai_dram_q;
        logic [31:0] ai_len_q;
        logic [5:0]  irq_q;
        logic [9:0]  line_q;

        function new();
            mismatches  = 0;
            events_seen = 0;
            headless    = MODE_TIMING;
            primed      = 1'b0;
            pi_busy_q   = 1'b0;
            si_busy_q   = 1'b0;
            ai_busy_q   = 1'b0;
            next_seq    = 64'd1;
            pi_cart_q   = '0;
            pi_dram_q   = '0;
            pi_len_q    = '0;
            si_dram_q   = '0;
            ai_dram_q   = '0;
            ai_len_q    = '0;
            irq_q       = '0;
            line_q      = '0;
        endfunction

        function void set_mode(bit mode);
            headless = mode;
        endfunction

        function void push_event(logic [2:0] kind, logic [2:0] dev, logic [31:0] cyc,
                                 logic [31:0] addr, logic [31:0] val, logic [31:0] dram);
            t_event e;
            e.seq  = next_seq;
            e.kind = kind;
            e.dev  = dev;
            e.cyc  = cyc;
            e.addr = addr;
            e.val  = val;
            e.dram = dram;
            e.last = 1'b0;
            poll_events.push_back(e);
            next_seq = next_seq + 64'd1;
        endfunction

        function void note_poll(t_poll p);
            bit          pi_b;
            bit          si_b;
            bit          ai_b;
            logic [31:0] len;
            logic [5:0]  irq_up;
            logic [5:0]  irq_dn;
            logic [31:0] src;
            pi_b = p.busy_flags[0];
            si_b = p.busy_flags[1];
            ai_b = p.busy_flags[2];
            // first poll after reset is the baseline
            if (!primed) begin
                primed    = 1'b1;
                pi_busy_q = pi_b;
                pi_cart_q = p.pi_cart_address;
                pi_dram_q = p.pi_dram_address;
                pi_len_q  = '0;
                si_busy_q = si_b;
                si_dram_q = p.si_dram_address;
                ai_busy_q = ai_b;
                ai_dram_q = p.ai_dram_address;
                ai_len_q  = p.ai_length;
                irq_q     = p.interrupt_bits;
                line_q    = p.video_line;
                return;
            end
            poll_events.delete();

            if (pi_b && !pi_busy_q) begin
                if (p.pi_read_length != LEN_IDLE)
                    len = p.pi_read_length + 32'd1;
                else if (p.pi_write_length != LEN_IDLE)
                    len = p.pi_write_length + 32'd1;
                else
                    len = '0;
                pi_cart_q = p.pi_cart_address;
                pi_dram_q = p.pi_dram_address;
                pi_len_q  = len;
                if (!headless)
                    push_event(KIND_DMA_START, DEV_PI, p.cycle_stamp, p.pi_cart_address,
                               len, '0);
            end else if (!pi_b && pi_busy_q) begin
                if (headless) begin
                    if (pi_len_q != '0)
                        push_event(KIND_PI_DONE, DEV_PI, p.cycle_stamp, pi_cart_q,
                                   pi_len_q, pi_dram_q);
                end else begin
                    push_event(KIND_DMA_DONE, DEV_PI, p.cycle_stamp, pi_cart_q, pi_len_q, '0);
                end
            end
            pi_busy_q = pi_b;

            if (si_b && !si_busy_q) begin
                si_dram_q = p.si_dram_address;
                push_event(KIND_DMA_START, DEV_SI, p.cycle_stamp, p.si_dram_address, '0, '0);
            end else if (!si_b && si_busy_q) begin
                push_event(KIND_DMA_DONE, DEV_SI, p.cycle_stamp, si_dram_q, '0, '0);
            end
            si_busy_q = si_b;

            if (ai_b && !ai_busy_q) begin
                ai_dram_q = p.ai_dram_address;
                ai_len_q  = p.ai_length;
                push_event(KIND_DMA_START, DEV_AI, p.cycle_stamp, p.ai_dram_address,
                           p.ai_length, '0);
            end else if (!ai_b && ai_busy_q) begin
                push_event(KIND_DMA_DONE, DEV_AI, p.cycle_stamp, ai_dram_q, ai_len_q, '0);
            end
            ai_busy_q = ai_b;

            irq_up = p.interrupt_bits & ~irq_q;
            irq_dn = irq_q & ~p.interrupt_bits;
            for (int k = 0; k < IRQ_N; k++) begin
                src = 32'd1 << k;
                if (irq_up[k])
                    push_event(KIND_IRQ_RAISE, DEV_MI, p.cycle_stamp, src, '0, '0);
                if (irq_dn[k])
                    push_event(KIND_IRQ_ACK, DEV_MI, p.cycle_stamp, src, '0, '0);
            end
            irq_q = p.interrupt_bits;

            if (p.video_line < line_q)
                push_event(KIND_RETRACE, DEV_VI, p.cycle_stamp, '0, '0, '0);
            line_q = p.video_line;

            if (poll_events.size() != 0)
                poll_events[poll_events.size() - 1].last = 1'b1;
            foreach (poll_events[i])
                events_due.push_back(poll_events[i]);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_event(t_event got);
            t_event want;
            if (events_due.size() == 0) begin
                $error("unexpected event word, sequence %0d", got.seq);
                mismatches++;
                return;
            end
            want = events_due.pop_front();
            events_seen++;
            compare_field("sequence_number", want.seq, got.seq);
            compare_field("event_type", 64'(want.kind), 64'(got.kind));
            compare_field("device_id", 64'(want.dev), 64'(got.dev));
            compare_field("event_cycle", 64'(want.cyc), 64'(got.cyc));
            compare_field("address_or_source", 64'(want.addr), 64'(got.addr));
            compare_field("value_or_length", 64'(want.val), 64'(got.val));
            compare_field("dram_address_out", 64'(want.dram), 64'(got.dram));
            compare_field("last_event", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_cycle_stamp;
    logic [2:0]  i_busy_flags;
    logic [31:0] i_pi_read_length;
    logic [31:0] i_pi_write_length;
    logic [31:0] i_pi_cart_address;
    logic [31:0] i_pi_dram_address;
    logic [31:0] i_si_dram_address;
    logic [31:0] i_ai_dram_address;
    logic [31:0] i_ai_length;
    logic [5:0]  i_interrupt_bits;
    logic [9:0]  i_video_line;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_sequence_number;
    logic [2:0]  o_event_type;
    logic [2:0]  o_device_id;
    logic [31:0] o_event_cycle;
    logic [31:0] o_address_or_source;
    logic [31:0] o_value_or_length;
    logic [31:0] o_dram_address_out;
    logic        o_last_event;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_edge_board     board;
    t_poll           last_poll;
    int unsigned     polls_sent;
    int unsigned     mode_writes;
    int unsigned     cycle_count;
    int unsigned     sender_idle_pct;
    int unsigned     stall_pct;

    device_event_edge_tracer uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_cycle_stamp       (i_cycle_stamp),
        .i_busy_flags        (i_busy_flags),
        .i_pi_read_length    (i_pi_read_length),
        .i_pi_write_length   (i_pi_write_length),
        .i_pi_cart_address   (i_pi_cart_address),
        .i_pi_dram_address   (i_pi_dram_address),
        .i_si_dram_address   (i_si_dram_address),
        .i_ai_dram_address   (i_ai_dram_address),
        .i_ai_length         (i_ai_length),
        .i_interrupt_bits    (i_interrupt_bits),
        .i_video_line        (i_video_line),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_sequence_number   (o_sequence_number),
        .o_event_type        (o_event_type),
        .o_device_id         (o_device_id),
        .o_event_cycle       (o_event_cycle),
        .o_address_or_source (o_address_or_source),
        .o_value_or_length   (o_value_or_length),
        .o_dram_address_out  (o_dram_address_out),
        .o_last_event        (o_last_event),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_event got;
        if (i_rst_n && o_valid && i_ready) begin
            got.seq  = o_sequence_number;
            got.kind = o_event_type;
            got.dev  = o_device_id;
            got.cyc  = o_event_cycle;
            got.addr = o_address_or_source;
            got.val  = o_value_or_length;
            got.dram = o_dram_address_out;
            got.last = o_last_event;
            board.check_event(got);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("timeout with %0d event words outstanding", board.events_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_poll poll_of(logic [31:0] cyc, logic [2:0] busy, logic [31:0] rd,
                                      logic [31:0] wr, logic [31:0] fill, logic [5:0] irq,
                                      logic [9:0] line);
        t_poll p;
        p.cycle_stamp     = cyc;
        p.busy_flags      = busy;
        p.pi_read_length  = rd;
        p.pi_write_length = wr;
        p.pi_cart_address = fill;
        p.pi_dram_address = ~fill;
        p.si_dram_address = fill ^ 32'h5A5A_5A5A;
        p.ai_dram_address = fill ^ 32'hA5A5_A5A5;
        p.ai_length       = fill;
        p.interrupt_bits  = irq;
        p.video_line      = line;
        return p;
    endfunction

    function automatic logic [31:0] pick_length();
        case ($urandom_range(4))
            0, 1:    return LEN_IDLE;
            2:       return 32'($urandom_range(0, 300));
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // mostly plausible next snapshots, some pure noise
    function automatic t_poll next_poll(t_poll prev);
        t_poll p;
        p = prev;
        p.pi_read_length  = pick_length();
        p.pi_write_length = pick_length();
        p.pi_cart_address = $urandom;
        p.pi_dram_address = $urandom;
        p.si_dram_address = $urandom;
        p.ai_dram_address = $urandom;
        p.ai_length       = $urandom;
        if ($urandom_range(99) < 15) begin
            p.cycle_stamp    = $urandom;
            p.busy_flags     = 3'($urandom);
            p.interrupt_bits = 6'($urandom);
            p.video_line     = 10'($urandom);
        end else begin
            p.cycle_stamp = prev.cycle_stamp + 32'($urandom_range(1, 4000));
            for (int k = 0; k < 3; k++)
                if ($urandom_range(99) < 30)
                    p.busy_flags[k] = ~prev.busy_flags[k];
            for (int k = 0; k < IRQ_N; k++)
                if ($urandom_range(99) < 20)
                    p.interrupt_bits[k] = ~prev.interrupt_bits[k];
            p.video_line = prev.video_line + 10'($urandom_range(0, 200));
        end
        return p;
    endfunction

    task automatic send_poll(input t_poll p);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_cycle_stamp     <= p.cycle_stamp;
        i_busy_flags      <= p.busy_flags;
        i_pi_read_length  <= p.pi_read_length;
        i_pi_write_length <= p.pi_write_length;
        i_pi_cart_address <= p.pi_cart_address;
        i_pi_dram_address <= p.pi_dram_address;
        i_si_dram_address <= p.si_dram_address;
        i_ai_dram_address <= p.ai_dram_address;
        i_ai_length       <= p.ai_length;
        i_interrupt_bits  <= p.interrupt_bits;
        i_video_line      <= p.video_line;
        i_valid           <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        board.note_poll(p);
        last_poll = p;
        polls_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (board.events_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_mode(input bit mode);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= 32'(mode);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_mode(mode);
        mode_writes++;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(mode)) begin
            $error("output_mode readback: expected %0h, got %0h", 32'(mode), prdata);
            board.mismatches++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_random(input bit mode, input int unsigned idle,
                              input int unsigned stall, input int unsigned n);
        t_poll p;
        write_mode(mode);
        sender_idle_pct = idle;
        stall_pct       = stall;
        repeat (n) begin
            p = next_poll(last_poll);
            send_poll(p);
        end
    endtask

    initial begin
        board             = new();
        polls_sent        = 0;
        mode_writes       = 0;
        cycle_count       = 0;
        sender_idle_pct   = 0;
        stall_pct         = 0;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_ready           = 1'b0;
        i_cycle_stamp     = '0;
        i_busy_flags      = '0;
        i_pi_read_length  = '0;
        i_pi_write_length = '0;
        i_pi_cart_address = '0;
        i_pi_dram_address = '0;
        i_si_dram_address = '0;
        i_ai_dram_address = '0;
        i_ai_length       = '0;
        i_interrupt_bits  = '0;
        i_video_line      = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, timing mode
        write_mode(MODE_TIMING);
        send_poll(poll_of(32'h0, 3'b000, 32'h0, 32'h0, 32'h0, 6'h00, 10'd0));
        send_poll(poll_of(32'hFFFF_FFFF, 3'b111, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                          6'h3F, 10'd1023));
        send_poll(poll_of(32'hFFFF_FFFF, 3'b000, 32'h0, 32'hFFFF_FFFF, 32'h0, 6'h00, 10'd0));
        send_poll(poll_of(32'd100, 3'b001, LEN_IDLE, 32'h10, 32'h1234_5678, 6'h01, 10'd5));
        send_poll(poll_of(32'd200, 3'b000, 32'h0, 32'h0, 32'h0, 6'h02, 10'd6));
        send_poll(poll_of(32'd300, 3'b001, LEN_IDLE, LEN_IDLE, $urandom, 6'h00, 10'd7));
        send_poll(poll_of(32'd400, 3'b000, 32'h0, 32'h0, 32'h0, 6'h00, 10'd7));
        send_poll(poll_of(32'd450, 3'b001, LEN_IDLE, 32'hFFFF_FFFF, $urandom, 6'h20, 10'd8));
        send_poll(poll_of(32'd500, 3'b010, 32'h0, 32'h0, $urandom, 6'h20, 10'd3));
        send_poll(poll_of(32'd600, 3'b110, 32'h0, 32'h0, 32'hDEAD_BEEF, 6'h20, 10'd3));
        send_poll(poll_of(32'd600, 3'b110, 32'h0, 32'h0, 32'hDEAD_BEEF, 6'h20, 10'd3));
        send_poll(poll_of(32'd700, 3'b001, 32'd5, 32'h0, 32'h0BAD_F00D, 6'h24, 10'd9));

        // directed, headless mode; the PI transfer above finishes here
        write_mode(MODE_HEADLESS);
        send_poll(poll_of(32'd800, 3'b000, 32'h0, 32'h0, 32'h0, 6'h24, 10'd10));
        send_poll(poll_of(32'd900, 3'b001, LEN_IDLE, LEN_IDLE, $urandom, 6'h24, 10'd11));
        send_poll(poll_of(32'd1000, 3'b000, 32'h0, 32'h0, 32'h0, 6'h24, 10'd12));
        send_poll(poll_of(32'd1100, 3'b111, 32'hFFFF_FFFE, 32'h0, 32'hFFFF_FFFF,
                          6'h3F, 10'd100));
        send_poll(poll_of(32'd1200, 3'b000, 32'h0, 32'h0, 32'h0, 6'h00, 10'd50));
        send_poll(poll_of(32'd1300, 3'b001, 32'h20, 32'h0, $urandom, 6'h00, 10'd60));

        // transfer started headless, finished in timing mode
        write_mode(MODE_TIMING);
        send_poll(poll_of(32'd1400, 3'b000, 32'h0, 32'h0, 32'h0, 6'h00, 10'd70));

        run_random(MODE_TIMING, 0, 0, 23);
        run_random(MODE_HEADLESS, 69, 0, 23);
        run_random(MODE_TIMING, 0, 69, 23);
        run_random(MODE_HEADLESS, 36, 36, 23);

        settle();
        repeat (16) @(negedge i_clk);
        if (board.events_due.size() != 0) begin
            $error("%0d expected event words never arrived", board.events_due.size());
            board.mismatches++;
        end
        $display("%0d polls sent, %0d event words checked, %0d mode writes",
                 polls_sent, board.events_seen, mode_writes);
        $display("covered both output modes, full ten-event polls, idle and stall phases");
        if (board.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
